@@ hw/rtl/mas_pkg.sv @@
// Shared types and constants for the modular add/sub/mul/mac unit.
package mas_pkg;

    localparam int WORD_WIDTH_DEF = 64;
    localparam int PORT_WIDTH     = 64;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_SUB = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_MAC = 2'd3;

    typedef struct packed {
        logic       valid;
        logic [1:0] mode;
    } ctl_t;

endpackage

@@ hw/rtl/mas_reduce.sv @@
// Operand reduction pipeline: one restoring step per stage, three lanes.
module mas_reduce #(
    parameter int W = mas_pkg::WORD_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [W-1:0]    q,
    input  mas_pkg::ctl_t   in_ctl,
    input  logic [W-1:0]    in_a,
    input  logic [W-1:0]    in_b,
    input  logic [W-1:0]    in_c,
    output mas_pkg::ctl_t   out_ctl,
    output logic [W-1:0]    out_a,
    output logic [W-1:0]    out_b,
    output logic [W-1:0]    out_c
);

    function automatic logic [W-1:0] red_step(input logic [W-1:0] rem, input logic bit_in,
                                              input logic [W-1:0] m);
        logic [W:0] t;
        begin
            t = {rem, bit_in};
            if (t >= {1'b0, m})
                t = t - {1'b0, m};
            return t[W-1:0];
        end
    endfunction

    mas_pkg::ctl_t ctl_reg   [W];
    logic [W-1:0]  a_raw_reg [W];
    logic [W-1:0]  b_raw_reg [W];
    logic [W-1:0]  c_raw_reg [W];
    logic [W-1:0]  a_rem_reg [W];
    logic [W-1:0]  b_rem_reg [W];
    logic [W-1:0]  c_rem_reg [W];

    genvar k;
    generate
        for (k = 0; k < W; k++) begin : g_stage
            localparam int BIT = W - 1 - k;
            mas_pkg::ctl_t ctl_in;
            logic [W-1:0]  a_raw, b_raw, c_raw, a_rem, b_rem, c_rem;

            if (k == 0) begin : g_first
                assign ctl_in = in_ctl;
                assign a_raw  = in_a;
                assign b_raw  = in_b;
                assign c_raw  = in_c;
                assign a_rem  = '0;
                assign b_rem  = '0;
                assign c_rem  = '0;
            end
            else begin : g_next
                assign ctl_in = ctl_reg[k-1];
                assign a_raw  = a_raw_reg[k-1];
                assign b_raw  = b_raw_reg[k-1];
                assign c_raw  = c_raw_reg[k-1];
                assign a_rem  = a_rem_reg[k-1];
                assign b_rem  = b_rem_reg[k-1];
                assign c_rem  = c_rem_reg[k-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    ctl_reg[k] <= '0;
                else
                    ctl_reg[k] <= ctl_in;
            end

            always_ff @(posedge clk)
            begin
                a_raw_reg[k] <= a_raw;
                b_raw_reg[k] <= b_raw;
                c_raw_reg[k] <= c_raw;
                a_rem_reg[k] <= red_step(a_rem, a_raw[BIT], q);
                b_rem_reg[k] <= red_step(b_rem, b_raw[BIT], q);
                c_rem_reg[k] <= red_step(c_rem, c_raw[BIT], q);
            end
        end
    endgenerate

    assign out_ctl = ctl_reg[W-1];
    assign out_a   = a_rem_reg[W-1];
    assign out_b   = b_rem_reg[W-1];
    assign out_c   = c_rem_reg[W-1];

endmodule

@@ hw/rtl/mas_mulmod.sv @@
// Modular multiply pipeline: double-and-add, at most one modular add per stage.
module mas_mulmod #(
    parameter int W = mas_pkg::WORD_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [W-1:0]    q,
    input  mas_pkg::ctl_t   in_ctl,
    input  logic [W-1:0]    in_a,
    input  logic [W-1:0]    in_b,
    input  logic [W-1:0]    in_c,
    output mas_pkg::ctl_t   out_ctl,
    output logic [W-1:0]    out_a,
    output logic [W-1:0]    out_b,
    output logic [W-1:0]    out_c,
    output logic [W-1:0]    out_p
);

    localparam int STAGES = 2 * W;

    // x, y < m
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic [W-1:0] m);
        logic [W:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            if (s >= {1'b0, m})
                s = s - {1'b0, m};
            return s[W-1:0];
        end
    endfunction

    mas_pkg::ctl_t ctl_reg [STAGES];
    logic [W-1:0]  a_reg   [STAGES];
    logic [W-1:0]  b_reg   [STAGES];
    logic [W-1:0]  c_reg   [STAGES];
    logic [W-1:0]  p_reg   [STAGES];

    genvar j;
    generate
        for (j = 0; j < STAGES; j++) begin : g_stage
            localparam int BIT = W - 1 - j / 2;
            mas_pkg::ctl_t ctl_in;
            logic [W-1:0]  a_in, b_in, c_in, p_in, p_out;

            if (j == 0) begin : g_first
                assign ctl_in = in_ctl;
                assign a_in   = in_a;
                assign b_in   = in_b;
                assign c_in   = in_c;
                assign p_in   = '0;
            end
            else begin : g_next
                assign ctl_in = ctl_reg[j-1];
                assign a_in   = a_reg[j-1];
                assign b_in   = b_reg[j-1];
                assign c_in   = c_reg[j-1];
                assign p_in   = p_reg[j-1];
            end

            // even stage doubles, odd stage adds a when the multiplier bit is set
            if ((j % 2) == 0) begin : g_dbl
                assign p_out = add_mod(p_in, p_in, q);
            end
            else begin : g_add
                assign p_out = b_in[BIT] ? add_mod(p_in, a_in, q) : p_in;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    ctl_reg[j] <= '0;
                else
                    ctl_reg[j] <= ctl_in;
            end

            always_ff @(posedge clk)
            begin
                a_reg[j] <= a_in;
                b_reg[j] <= b_in;
                c_reg[j] <= c_in;
                p_reg[j] <= p_out;
            end
        end
    endgenerate

    assign out_ctl = ctl_reg[STAGES-1];
    assign out_a   = a_reg[STAGES-1];
    assign out_b   = b_reg[STAGES-1];
    assign out_c   = c_reg[STAGES-1];
    assign out_p   = p_reg[STAGES-1];

endmodule

@@ hw/rtl/mas_final.sv @@
// Final stage: mode select, last modular add or subtract, output register.
module mas_final #(
    parameter int W = mas_pkg::WORD_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [W-1:0]    q,
    input  mas_pkg::ctl_t   in_ctl,
    input  logic [W-1:0]    in_a,
    input  logic [W-1:0]    in_b,
    input  logic [W-1:0]    in_c,
    input  logic [W-1:0]    in_p,
    output logic            out_valid,
    output logic [W-1:0]    out_result
);

    logic [W-1:0] x, y;
    logic [W:0]   sum;
    logic [W-1:0] res_next;
    logic         valid_reg;
    logic [W-1:0] result_reg;

    always_comb
    begin
        x   = in_a;
        y   = in_b;
        sum = '0;
        case (in_ctl.mode)
            mas_pkg::MODE_ADD: begin x = in_a; y = in_b; end
            mas_pkg::MODE_SUB: begin x = in_a; y = in_b; end
            mas_pkg::MODE_MUL: begin x = in_p; y = '0;   end
            mas_pkg::MODE_MAC: begin x = in_c; y = in_p; end
            default:           begin x = in_a; y = in_b; end
        endcase
        if (in_ctl.mode == mas_pkg::MODE_SUB)
        begin
            if (x >= y)
                res_next = x - y;
            else
                res_next = x + (q - y);
        end
        else
        begin
            sum = {1'b0, x} + {1'b0, y};
            if (sum >= {1'b0, q})
                sum = sum - {1'b0, q};
            res_next = sum[W-1:0];
        end
        // zero modulus: result forced to zero
        if (q == '0)
            res_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= res_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

@@ hw/rtl/modular_add_sub_mul_mac_unit.sv @@
// Throughput: one word per cycle; busy is always low, every stage holds one word.
// Depth is set by the operand reduction (one bit per stage) and the
// double-and-add multiply (two stages per bit). Result strobe cannot be stalled.
// Reset: pipeline valid bits cleared, modulus register set to 1.
// Top level of the modular add/sub/mul/mac unit.
module modular_add_sub_mul_mac_unit #(
    parameter int WORD_WIDTH = mas_pkg::WORD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: modulus register
    input  logic                            modulus_we,
    input  logic [mas_pkg::PORT_WIDTH-1:0]  modulus_wdata,
    // command side
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      mode,
    input  logic [mas_pkg::PORT_WIDTH-1:0]  lhs,
    input  logic [mas_pkg::PORT_WIDTH-1:0]  rhs,
    input  logic [mas_pkg::PORT_WIDTH-1:0]  accum_in,
    // result side
    output logic                            result_valid,
    output logic [mas_pkg::PORT_WIDTH-1:0]  result
);

    logic [mas_pkg::PORT_WIDTH-1:0] modulus_reg;
    logic [WORD_WIDTH-1:0]          q;

    mas_pkg::ctl_t         in_ctl, red_ctl, mul_ctl;
    logic [WORD_WIDTH-1:0] red_a, red_b, red_c;
    logic [WORD_WIDTH-1:0] mul_a, mul_b, mul_c, mul_p;
    logic [WORD_WIDTH-1:0] res_w;

    // User must rewrite modulus only while the pipeline is empty; not enforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= mas_pkg::PORT_WIDTH'(1);
        else if (modulus_we)
            modulus_reg <= modulus_wdata;
    end

    assign q = modulus_reg[WORD_WIDTH-1:0];

    // Fully pipelined: a word is taken every cycle start is high.
    assign busy         = 1'b0;
    assign in_ctl.valid = start;
    assign in_ctl.mode  = mode;

    // Stage group 1: bring each operand below q, MSB first.
    mas_reduce #(.W(WORD_WIDTH)) u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .q       (q),
        .in_ctl  (in_ctl),
        .in_a    (lhs[WORD_WIDTH-1:0]),
        .in_b    (rhs[WORD_WIDTH-1:0]),
        .in_c    (accum_in[WORD_WIDTH-1:0]),
        .out_ctl (red_ctl),
        .out_a   (red_a),
        .out_b   (red_b),
        .out_c   (red_c)
    );

    // Stage group 2: reduced product by modular double-and-add.
    mas_mulmod #(.W(WORD_WIDTH)) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .q       (q),
        .in_ctl  (red_ctl),
        .in_a    (red_a),
        .in_b    (red_b),
        .in_c    (red_c),
        .out_ctl (mul_ctl),
        .out_a   (mul_a),
        .out_b   (mul_b),
        .out_c   (mul_c),
        .out_p   (mul_p)
    );

    // Stage 3: pick by mode, final add/sub mod q, register out.
    mas_final #(.W(WORD_WIDTH)) u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .q          (q),
        .in_ctl     (mul_ctl),
        .in_a       (mul_a),
        .in_b       (mul_b),
        .in_c       (mul_c),
        .in_p       (mul_p),
        .out_valid  (result_valid),
        .out_result (res_w)
    );

    assign result = mas_pkg::PORT_WIDTH'(res_w);

endmodule
